// ----- src/tdd_pkg.sv -----
// ============================================================================
// tdd_pkg: shared types and constants for the tile dedup dictionary
// Table geometry, field widths, sequencer states and the RAM request bundle.
// ============================================================================
package tdd_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int TILE_ROWS   = 6;

    localparam int TILE_W  = 48;
    localparam int INDEX_W = 11;
    localparam int COUNT_W = 12;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // Fill level spans 0..TABLE_DEPTH inclusive.
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W = CNT_W + COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [TILE_W-1:0] wr_data;
    } t_ram_req;

    // Keeps the low TILE_ROWS byte rows; rows past the input are absent anyway.
    function automatic logic [TILE_W-1:0] row_mask();
        logic [TILE_W-1:0] m;
        m = '0;
        for (int r = 0; r < TILE_W / 8; r++) begin
            if (r < TILE_ROWS) begin
                m[r*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    localparam logic [TILE_W-1:0] TILE_MASK = row_mask();

    // Reduce a fill-level value to the reported field widths.
    function automatic logic [INDEX_W-1:0] to_index(input logic [CNT_W-1:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[INDEX_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[COUNT_W-1:0];
    endfunction

endpackage

// ----- src/tdd_if.sv -----
// ============================================================================
// tdd_if: stream channels of the tile dedup dictionary
// Tile input channel and lookup result channel, valid/ready handshake.
// ============================================================================
interface tdd_tile_if;
    logic                      valid;
    logic                      ready;
    logic [tdd_pkg::TILE_W-1:0] tile_bits;

    modport source (output valid, output tile_bits, input ready);
    modport sink   (input valid, input tile_bits, output ready);
endinterface

interface tdd_result_if;
    logic                        valid;
    logic                        ready;
    logic [tdd_pkg::INDEX_W-1:0] tile_index;
    logic                        was_new;
    logic                        table_full;
    logic [tdd_pkg::COUNT_W-1:0] tile_count;

    modport source (output valid, output tile_index, output was_new,
                    output table_full, output tile_count, input ready);
    modport sink   (input valid, input tile_index, input was_new,
                    input table_full, input tile_count, output ready);
endinterface

// ----- src/tile_dedup_dictionary.sv -----
// ============================================================================
// tile_dedup_dictionary: dictionary of distinct character tiles
// Linear search of the stored tiles, append on miss, one result per tile.
// ============================================================================
// Each tile transfer is looked up against the tiles stored so far, oldest
// first. A hit reports the stored index; a miss appends the tile at the
// current fill level (was_new set) or, with the table full, reports index 0
// with table_full set. One tile is in work at a time. A miss on a non-empty
// table runs through these steps: accept, one RAM read per stored entry
// through the single read port, the read latency for the last compare, the
// close of the scan, and the issue of the result and the append write, which
// waits until the result register is free. A hit stops the scan early. The
// result register lets a new tile transfer in while the previous result
// still waits downstream. Appends and scans never overlap, so the sequencer
// itself is the interlock on the store.
module tile_dedup_dictionary (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tdd_tile_if.sink             i_tile,
    tdd_result_if.source         o_result
);

    localparam int CNT_W  = tdd_pkg::CNT_W;
    localparam int ADDR_W = tdd_pkg::ADDR_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(tdd_pkg::TABLE_DEPTH);

    tdd_pkg::t_state r_state, n_state;

    // Fill level of the store.
    logic [CNT_W-1:0] r_count, n_count;

    // Tile under search, masked to the compared rows.
    logic [tdd_pkg::TILE_W-1:0] r_tile;

    // Scan pointer and the compare stage, registered behind it.
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_chk_vld, n_chk_vld;
    logic [ADDR_W-1:0] r_chk_idx;

    // Outcome of the scan.
    logic              r_hit;
    logic [ADDR_W-1:0] r_hit_idx;

    // Result register.
    logic                        r_out_valid, n_out_valid;
    logic [tdd_pkg::INDEX_W-1:0] r_out_index, n_out_index;
    logic                        r_out_new, n_out_new;
    logic                        r_out_full, n_out_full;
    logic [tdd_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    tdd_pkg::t_ram_req          ram_req;
    logic [tdd_pkg::TILE_W-1:0] rd_data;

    logic in_xfer;
    logic out_free;
    logic more;
    logic hit;
    logic scan_done;
    logic room;

    tdd_tile_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign in_xfer   = i_tile.valid && i_tile.ready;
    assign out_free  = !r_out_valid || o_result.ready;
    assign more      = (r_idx < r_count);
    assign hit       = r_chk_vld && (rd_data == r_tile);
    // Nothing in flight and nothing left to read: a clean miss.
    assign scan_done = !r_chk_vld && !more;
    assign room      = (r_count != DEPTH_CNT);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = tdd_pkg::ST_SEARCH;
                end
            end
            tdd_pkg::ST_SEARCH: begin
                if (hit || scan_done) begin
                    n_state = tdd_pkg::ST_RESULT;
                end
            end
            tdd_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = tdd_pkg::ST_IDLE;
                end
            end
            default: n_state = tdd_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        i_tile.ready = 1'b0;
        n_idx        = r_idx;
        n_chk_vld    = 1'b0;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_index  = r_out_index;
        n_out_new    = r_out_new;
        n_out_full   = r_out_full;
        n_out_count  = r_out_count;

        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = r_idx[ADDR_W-1:0];
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = r_count[ADDR_W-1:0];
        ram_req.wr_data = r_tile;

        case (r_state)
            tdd_pkg::ST_IDLE: begin
                i_tile.ready = 1'b1;
                n_idx        = '0;
            end
            tdd_pkg::ST_SEARCH: begin
                // Stop issuing reads once a match is seen.
                ram_req.rd_en = more && !hit;
                n_chk_vld     = more && !hit;
                if (more && !hit) begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            tdd_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_hit) begin
                        n_out_index = tdd_pkg::to_index(CNT_W'(r_hit_idx));
                        n_out_new   = 1'b0;
                        n_out_full  = 1'b0;
                        n_out_count = tdd_pkg::to_count(r_count);
                    end else if (room) begin
                        ram_req.wr_en = 1'b1;
                        n_count       = r_count + CNT_W'(1);
                        n_out_index   = tdd_pkg::to_index(r_count);
                        n_out_new     = 1'b1;
                        n_out_full    = 1'b0;
                        n_out_count   = tdd_pkg::to_count(r_count + CNT_W'(1));
                    end else begin
                        n_out_index = '0;
                        n_out_new   = 1'b0;
                        n_out_full  = 1'b1;
                        n_out_count = tdd_pkg::to_count(r_count);
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdd_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_tile <= i_tile.tile_bits & tdd_pkg::TILE_MASK;
        end
        if (ram_req.rd_en) begin
            r_chk_idx <= r_idx[ADDR_W-1:0];
        end
        if (r_state == tdd_pkg::ST_SEARCH && (hit || scan_done)) begin
            r_hit     <= hit;
            r_hit_idx <= r_chk_idx;
        end
        r_out_index <= n_out_index;
        r_out_new   <= n_out_new;
        r_out_full  <= n_out_full;
        r_out_count <= n_out_count;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.tile_index = r_out_index;
    assign o_result.was_new    = r_out_new;
    assign o_result.table_full = r_out_full;
    assign o_result.tile_count = r_out_count;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("fill level past table depth");

    a_new_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_new && r_out_full))
        else $error("result both new and full");

    a_write_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.wr_en |-> (r_state == tdd_pkg::ST_RESULT) && !ram_req.rd_en)
        else $error("store write outside result step");

    a_count_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ram_req.wr_en |=> $stable(r_count))
        else $error("fill level moved without append");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == tdd_pkg::ST_SEARCH) && (r_idx == '0))
        else $error("accepted tile did not start a scan");

endmodule

// ----- src/tdd_tile_ram.sv -----
// ============================================================================
// tdd_tile_ram: tile store
// One write port, one read port, registered read data.
// ============================================================================
module tdd_tile_ram (
    input  logic                       i_clk,
    input  tdd_pkg::t_ram_req          i_req,
    output logic [tdd_pkg::TILE_W-1:0] o_rd_data
);

    logic [tdd_pkg::TILE_W-1:0] mem [tdd_pkg::TABLE_DEPTH];
    logic [tdd_pkg::TILE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
